>>> rtl/first_fit_region_allocator_macros.svh
// assertion macros for the first-fit region allocator checker
`ifndef FIRST_FIT_REGION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FFRA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define FFRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ffra_pkg.sv
// shared types, constants and codes of the first-fit region allocator
`timescale 1ns / 1ps

package ffra_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BYTES  = 4096;

	localparam int ADDR_W     = 48;
	localparam int PAGES_W    = 20;
	localparam int ACTION_W   = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int SIZE_W     = PAGES_W + PAGE_SHIFT;
	localparam int IDX_W      = $clog2(MAX_REGIONS);
	localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
	// candidate base may run one bit past the address space (region end)
	localparam int CAND_W     = ADDR_W + 1;
	localparam int SUM_W      = CAND_W + 1;

	localparam logic [ADDR_W-1:0] RANGE_START_RST = 48'h0000_0040_0000;
	localparam logic [ADDR_W-1:0] RANGE_LIMIT_RST = 48'h8000_0000_0000;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 1'd1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_ZERO     = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_NOROOM   = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [PAGES_W-1:0]  page_count;
		logic [ADDR_W-1:0]   free_base;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] region_addr;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [PAGES_W-1:0] pages;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CEND,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_LIMIT,
		S_UP_RD,
		S_UP_WR,
		S_INSERT,
		S_FR_RD,
		S_FR_CMP,
		S_DN_RD,
		S_DN_WR
	} fsm_state_t;

endpackage

>>> rtl/ffra_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/first_fit_region_allocator.sv
// top level of the first-fit region allocator: sequencer, shared adder and table ram
`timescale 1ns / 1ps

// First-fit region allocator. A command is taken when start is high and busy is
// low; busy then stays high until the command is finished, though a command
// answered straight from idle never raises busy. Every command gives exactly
// one result, shown on result for one cycle with done high; the receiver cannot
// stall it, so it must take the transaction in that cycle. A new command may be
// started in the same cycle that done is high. The region table (base, pages)
// lives in a small ram with one write and one registered read port, so every table
// entry touched costs a read step and a compare or write step, and one shared
// 50-bit adder forms both candidate ends and region ends. Steps, then done:
//   allocate: candidate end, per entry scanned a read and a compare (a raise
//             forms a new candidate end), limit check, per entry shifted up a
//             read and a write, then the insert
//   free:     a read and a compare per entry, then a read and a write per shift
//   allocate rejected for zero size or full table, clear, unused code: from idle
// Range registers are written through the cfg channel, which is always ready;
// write them only while the block is idle. No clearing pass is needed after reset.
module first_fit_region_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	// command transaction
	input  logic                           start,
	output logic                           busy,
	input  ffra_pkg::cmd_t                 cmd,
	// result transaction
	output logic                           done,
	output ffra_pkg::result_t              result,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffra_pkg::ADDR_W-1:0]    cfg_data
);

	// sequencer state
	ffra_pkg::fsm_state_t state_q, state_d;

	// configuration registers
	logic [ffra_pkg::ADDR_W-1:0] start_addr_q;
	logic [ffra_pkg::ADDR_W-1:0] limit_addr_q;

	// table bookkeeping: idx walks the table, mv walks a shift
	logic [ffra_pkg::CNT_W-1:0] count_q, count_d;
	logic [ffra_pkg::CNT_W-1:0] idx_q, idx_d;
	logic [ffra_pkg::CNT_W-1:0] mv_q, mv_d;
	logic [ffra_pkg::CNT_W-1:0] idx_p1, mv_p1, mv_m1;

	// request payload held for the whole command
	logic [ffra_pkg::SIZE_W-1:0]  size_q, size_d;
	logic [ffra_pkg::PAGES_W-1:0] pages_q, pages_d;
	logic [ffra_pkg::ADDR_W-1:0]  fbase_q, fbase_d;

	// first-fit candidate base and its end (candidate + request size)
	logic [ffra_pkg::CAND_W-1:0] cand_q, cand_d;
	logic [ffra_pkg::SUM_W-1:0]  cend_q, cend_d;

	// result register
	logic                 done_q, done_d;
	ffra_pkg::result_t    result_q, result_d;

	// table ram ports
	logic                       ram_we;
	logic [ffra_pkg::IDX_W-1:0] ram_waddr;
	logic [ffra_pkg::IDX_W-1:0] ram_raddr;
	ffra_pkg::entry_t           ram_wdata;
	ffra_pkg::entry_t           rd_entry;
	logic [ffra_pkg::ENTRY_W-1:0] ram_rdata;

	// shared adder
	logic [ffra_pkg::SUM_W-1:0] add_a, add_b, add_sum;

	ffra_ram #(
		.WIDTH (ffra_pkg::ENTRY_W),
		.DEPTH (ffra_pkg::MAX_REGIONS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = ffra_pkg::entry_t'(ram_rdata);

	assign idx_p1 = idx_q + ffra_pkg::CNT_W'(1);
	assign mv_p1  = mv_q + ffra_pkg::CNT_W'(1);
	assign mv_m1  = mv_q - ffra_pkg::CNT_W'(1);

	// while scanning an entry the adder forms the region end (base + pages * page size);
	// otherwise it forms the candidate end (candidate + request size)
	always_comb begin
		if (state_q == ffra_pkg::S_SCAN_CMP) begin
			add_a = ffra_pkg::SUM_W'(rd_entry.base);
			add_b = ffra_pkg::SUM_W'({rd_entry.pages, {ffra_pkg::PAGE_SHIFT{1'b0}}});
		end else begin
			add_a = ffra_pkg::SUM_W'(cand_q);
			add_b = ffra_pkg::SUM_W'(size_q);
		end
	end

	assign add_sum = add_a + add_b;

	// sequencer: next state, register updates and table accesses
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		mv_d      = mv_q;
		size_d    = size_q;
		pages_d   = pages_q;
		fbase_d   = fbase_q;
		cand_d    = cand_q;
		cend_d    = cend_q;
		done_d    = 1'b0;
		result_d  = result_q;
		ram_we    = 1'b0;
		ram_waddr = mv_q[ffra_pkg::IDX_W-1:0];
		ram_wdata = rd_entry;
		ram_raddr = idx_q[ffra_pkg::IDX_W-1:0];

		unique case (state_q)
			ffra_pkg::S_IDLE: begin
				if (start) begin
					result_d.region_addr = '0;
					result_d.status      = ffra_pkg::STAT_OK;
					unique case (cmd.action)
						ffra_pkg::ACT_ALLOC: begin
							if (cmd.page_count == '0) begin
								done_d          = 1'b1;
								result_d.status = ffra_pkg::STAT_ZERO;
							end else if (count_q == ffra_pkg::CNT_W'(ffra_pkg::MAX_REGIONS)) begin
								done_d          = 1'b1;
								result_d.status = ffra_pkg::STAT_FULL;
							end else begin
								cand_d  = ffra_pkg::CAND_W'(start_addr_q);
								idx_d   = '0;
								pages_d = cmd.page_count;
								size_d  = {cmd.page_count, {ffra_pkg::PAGE_SHIFT{1'b0}}};
								state_d = ffra_pkg::S_CEND;
							end
						end
						ffra_pkg::ACT_FREE: begin
							idx_d   = '0;
							fbase_d = cmd.free_base;
							state_d = ffra_pkg::S_FR_RD;
						end
						ffra_pkg::ACT_CLEAR: begin
							count_d = '0;
							done_d  = 1'b1;
						end
						default: begin
							// unused action code: no effect, plain ok
							done_d = 1'b1;
						end
					endcase
				end
			end

			// candidate end for the current candidate base
			ffra_pkg::S_CEND: begin
				cend_d = add_sum;
				if (idx_q == count_q) begin
					state_d = ffra_pkg::S_LIMIT;
				end else begin
					state_d = ffra_pkg::S_SCAN_RD;
				end
			end

			ffra_pkg::S_SCAN_RD: begin
				state_d = ffra_pkg::S_SCAN_CMP;
			end

			// does the request fit below this entry? if not, raise the candidate
			// to the entry end when that end is higher
			ffra_pkg::S_SCAN_CMP: begin
				if (cend_q <= ffra_pkg::SUM_W'(rd_entry.base)) begin
					state_d = ffra_pkg::S_LIMIT;
				end else begin
					idx_d = idx_p1;
					if (add_sum > ffra_pkg::SUM_W'(cand_q)) begin
						cand_d  = add_sum[ffra_pkg::CAND_W-1:0];
						state_d = ffra_pkg::S_CEND;
					end else if (idx_p1 == count_q) begin
						state_d = ffra_pkg::S_LIMIT;
					end else begin
						state_d = ffra_pkg::S_SCAN_RD;
					end
				end
			end

			// idx now holds the insert slot
			ffra_pkg::S_LIMIT: begin
				if (cend_q > ffra_pkg::SUM_W'(limit_addr_q)) begin
					done_d          = 1'b1;
					result_d.status = ffra_pkg::STAT_NOROOM;
					state_d         = ffra_pkg::S_IDLE;
				end else begin
					mv_d    = count_q;
					state_d = ffra_pkg::S_UP_RD;
				end
			end

			// make room: move entries from the top down to the slot one place up
			ffra_pkg::S_UP_RD: begin
				if (mv_q == idx_q) begin
					state_d = ffra_pkg::S_INSERT;
				end else begin
					ram_raddr = mv_m1[ffra_pkg::IDX_W-1:0];
					state_d   = ffra_pkg::S_UP_WR;
				end
			end

			ffra_pkg::S_UP_WR: begin
				ram_we  = 1'b1;
				mv_d    = mv_m1;
				state_d = ffra_pkg::S_UP_RD;
			end

			ffra_pkg::S_INSERT: begin
				ram_we               = 1'b1;
				ram_waddr            = idx_q[ffra_pkg::IDX_W-1:0];
				ram_wdata.base       = cand_q[ffra_pkg::ADDR_W-1:0];
				ram_wdata.pages      = pages_q;
				count_d              = count_q + ffra_pkg::CNT_W'(1);
				done_d               = 1'b1;
				result_d.region_addr = cand_q[ffra_pkg::ADDR_W-1:0];
				state_d              = ffra_pkg::S_IDLE;
			end

			// free: find the lowest entry whose base matches
			ffra_pkg::S_FR_RD: begin
				if (idx_q == count_q) begin
					done_d          = 1'b1;
					result_d.status = ffra_pkg::STAT_NOTFOUND;
					state_d         = ffra_pkg::S_IDLE;
				end else begin
					state_d = ffra_pkg::S_FR_CMP;
				end
			end

			ffra_pkg::S_FR_CMP: begin
				if (rd_entry.base == fbase_q) begin
					mv_d    = idx_q;
					state_d = ffra_pkg::S_DN_RD;
				end else begin
					idx_d   = idx_p1;
					state_d = ffra_pkg::S_FR_RD;
				end
			end

			// close the gap: move later entries one place down
			ffra_pkg::S_DN_RD: begin
				if (mv_p1 == count_q) begin
					count_d = count_q - ffra_pkg::CNT_W'(1);
					done_d  = 1'b1;
					state_d = ffra_pkg::S_IDLE;
				end else begin
					ram_raddr = mv_p1[ffra_pkg::IDX_W-1:0];
					state_d   = ffra_pkg::S_DN_WR;
				end
			end

			ffra_pkg::S_DN_WR: begin
				ram_we  = 1'b1;
				mv_d    = mv_p1;
				state_d = ffra_pkg::S_DN_RD;
			end

			default: begin
				state_d = ffra_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffra_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			done_q       <= 1'b0;
			start_addr_q <= ffra_pkg::RANGE_START_RST;
			limit_addr_q <= ffra_pkg::RANGE_LIMIT_RST;
		end else begin
			count_q <= count_d;
			done_q  <= done_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					ffra_pkg::REG_RANGE_START: start_addr_q <= cfg_data;
					ffra_pkg::REG_RANGE_LIMIT: limit_addr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		mv_q     <= mv_d;
		size_q   <= size_d;
		pages_q  <= pages_d;
		fbase_q  <= fbase_d;
		cand_q   <= cand_d;
		cend_q   <= cend_d;
		result_q <= result_d;
	end

	assign busy      = (state_q != ffra_pkg::S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

endmodule

>>> rtl/ffra_chk.sv
// port-level checker for the first-fit region allocator and its bind
`timescale 1ns / 1ps
`include "first_fit_region_allocator_macros.svh"

module ffra_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input ffra_pkg::result_t              result
);

	logic cmd_accept;
	logic result_fail;

	assign cmd_accept  = start && !busy;
	assign result_fail = done && (result.status != ffra_pkg::STAT_OK);

	// an accepted transaction either finishes at once or keeps the block busy
	`FFRA_ASSERT_NEXT(a_accept_progress, cmd_accept, done || busy, "accepted command vanished")

	// the block is never still busy while it shows a result
	`FFRA_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while busy")

	// leaving busy always comes with a result
	`FFRA_ASSERT_NOW(a_busy_ends_done, $fell(busy), done, "command ended without result")

	// a failed transaction reports address zero
	`FFRA_ASSERT_NOW(a_fail_addr_zero, result_fail, result.region_addr == '0,
		"failed result with nonzero address")

endmodule

bind first_fit_region_allocator ffra_chk u_ffra_chk (.*);

>>> verif/tb_first_fit_region_allocator.sv
// self-checking testbench for the first-fit region allocator
`timescale 1ns / 1ps

module tb_first_fit_region_allocator;

	import ffra_pkg::*;

	// the one action code the package leaves unnamed, a no-op in the block
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam logic [ADDR_W-1:0]   ADDR_ALL = {ADDR_W{1'b1}};

	// dut ports; the inputs are all driven to known values from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	cmd_t                 cmd       = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data  = '0;

	// shadow copy of the region table and of the range registers
	logic [ADDR_W-1:0]  tbl_base  [MAX_REGIONS];
	logic [PAGES_W-1:0] tbl_pages [MAX_REGIONS];
	int                 tbl_count;
	logic [ADDR_W-1:0]  win_start;
	logic [ADDR_W-1:0]  win_limit;

	// results owed by the block, oldest first
	result_t awaited_results [$];
	int      mismatch_count = 0;

	// sender idling: percent chance of a gap, and a stretch of gap-free commands
	int idle_pct   = 0;
	int burst_left = 0;

	first_fit_region_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[ADDR_W-1:0];
	endfunction

	function automatic cmd_t make_cmd(input logic [ACTION_W-1:0] act,
		input logic [PAGES_W-1:0] pages, input logic [ADDR_W-1:0] base);
		cmd_t c;
		c.action     = act;
		c.page_count = pages;
		c.free_base  = base;
		return c;
	endfunction

	// applies one command to the shadow table and gives the result it must cause
	function automatic result_t table_outcome(input cmd_t c);
		result_t     r;
		logic [63:0] size;
		logic [63:0] cand;
		logic [63:0] rend;
		int          slot;
		int          hit;
		bit          found;
		r.region_addr = '0;
		r.status      = STAT_OK;
		found         = 1'b0;
		case (c.action)
			ACT_ALLOC: begin
				// zero size is reported ahead of a full table
				if (c.page_count == '0) begin
					r.status = STAT_ZERO;
				end else if (tbl_count >= MAX_REGIONS) begin
					r.status = STAT_FULL;
				end else begin
					// first fit: walk up from the range start past every overlapping region
					size = 64'(c.page_count) * 64'(PAGE_BYTES);
					cand = 64'(win_start);
					slot = tbl_count;
					for (int i = 0; i < tbl_count; i++) begin
						if (!found) begin
							if (cand + size <= 64'(tbl_base[i])) begin
								slot  = i;
								found = 1'b1;
							end else begin
								rend = 64'(tbl_base[i]) + 64'(tbl_pages[i]) * 64'(PAGE_BYTES);
								if (rend > cand)
									cand = rend;
							end
						end
					end
					// 64-bit sums, so an end past the address space never wraps
					if (cand + size > 64'(win_limit)) begin
						r.status = STAT_NOROOM;
					end else begin
						for (int i = tbl_count; i > slot; i--) begin
							tbl_base[i]  = tbl_base[i-1];
							tbl_pages[i] = tbl_pages[i-1];
						end
						tbl_base[slot]  = cand[ADDR_W-1:0];
						tbl_pages[slot] = c.page_count;
						tbl_count++;
						r.region_addr = cand[ADDR_W-1:0];
					end
				end
			end
			ACT_FREE: begin
				// lowest matching entry goes, later ones shift down
				hit = -1;
				for (int i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl_base[i] == c.free_base)
						hit = i;
				if (hit < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					for (int j = hit; j + 1 < tbl_count; j++) begin
						tbl_base[j]  = tbl_base[j+1];
						tbl_pages[j] = tbl_pages[j+1];
					end
					tbl_count--;
				end
			end
			ACT_CLEAR: begin
				tbl_count = 0;
			end
			default: begin
				// unused code: no change, ok status
			end
		endcase
		return r;
	endfunction

	// one command transaction; any idle gap comes before start is raised
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			// mostly short gaps, some long enough to land deep in an allocate
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
		end else if ($urandom_range(0, 24) == 0) begin
			burst_left = 12;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		// taken at this edge
		awaited_results.push_back(table_outcome(c));
	endtask

	// sender pauses until the block has answered everything
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// both range registers, written only with the block idle
	task automatic set_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= REG_RANGE_START;
		cfg_data  <= lo;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		win_start = lo;
		cfg_index <= REG_RANGE_LIMIT;
		cfg_data  <= hi;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		win_limit = hi;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// every result transaction is matched against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		bit      bad;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: region_addr=%h status=%0d",
						result.region_addr, result.status);
			end else begin
				want = awaited_results.pop_front();
				bad  = 1'b0;
				if (result.region_addr !== want.region_addr)
					bad = 1'b1;
				if (result.status !== want.status)
					bad = 1'b1;
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: region_addr exp=%h act=%h status exp=%0d act=%0d",
							want.region_addr, result.region_addr, want.status, result.status);
				end
			end
		end
	end

	// reset register values: basic allocate, first fit into a hole, free misses,
	// unused code, filling the table, zero size ahead of full, clear
	task automatic test_basic_ops();
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd0, ADDR_ALL));
		send_cmd(make_cmd(ACT_ALLOC, 20'hFFFFF, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd2, '0));
		// removing the lowest entry shifts the rest down
		send_cmd(make_cmd(ACT_FREE, 20'hFFFFF, RANGE_START_RST));
		// the freed hole at the range start is taken first
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_FREE, '0, ADDR_ALL));
		send_cmd(make_cmd(ACT_FREE, '0, '0));
		send_cmd(make_cmd(ACT_NONE, 20'hFFFFF, ADDR_ALL));
		while (tbl_count < MAX_REGIONS)
			send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd0, '0));
		send_cmd(make_cmd(ACT_CLEAR, 20'hFFFFF, ADDR_ALL));
	endtask

	// range register extremes: region at address zero, no room near the top of
	// the address space without wrap, start above limit, zero limit
	task automatic test_range_edges();
		set_range('0, ADDR_ALL);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'hFFFFF, '0));
		send_cmd(make_cmd(ACT_FREE, '0, '0));
		send_cmd(make_cmd(ACT_CLEAR, '0, '0));
		set_range(ADDR_ALL - 48'hFFF, ADDR_ALL);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		set_range(ADDR_ALL - 48'h1FFF, ADDR_ALL);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_CLEAR, '0, '0));
		set_range(48'h10_0000, '0);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		set_range('0, '0);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		// exact fit at the limit, then nothing left
		set_range(48'h2000, 48'h3000);
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
		send_cmd(make_cmd(ACT_ALLOC, 20'd1, '0));
	endtask

	// random traffic in segments, each under a fresh range setting; mostly allocates
	// and frees of live bases so the table fills, empties and runs out of room
	task automatic test_random_phase(input int pct, input int segments, input int per_seg);
		int                 mode;
		int                 pick;
		logic [ADDR_W-1:0]  lo;
		logic [ADDR_W-1:0]  hi;
		logic [PAGES_W-1:0] pages;
		logic [ADDR_W-1:0]  base;
		cmd_t               c;
		for (int s = 0; s < segments; s++) begin
			mode = $urandom_range(0, 5);
			if (mode <= 3) begin
				// tight window, at most 200 pages
				lo = 48'($urandom_range(0, 1023)) << 12;
				if ($urandom_range(0, 3) == 0)
					lo = lo | 48'($urandom_range(1, 4095));
				hi = lo + (48'($urandom_range(8, 200)) << 12);
			end else if (mode == 4) begin
				lo = rand_addr();
				hi = rand_addr();
			end else begin
				lo = 48'($urandom_range(0, 255)) << 20;
				hi = ADDR_ALL;
			end
			set_range(lo, hi);
			idle_pct   = pct;
			burst_left = 0;
			for (int n = 0; n < per_seg; n++) begin
				pick  = $urandom_range(0, 99);
				pages = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(1, 8));
				base  = rand_addr();
				if (pick < 52) begin
					c = make_cmd(ACT_ALLOC, pages, base);
				end else if (pick < 82) begin
					// free of a live base, or a near miss just past it
					if (tbl_count > 0)
						base = tbl_base[$urandom_range(0, tbl_count - 1)];
					if ($urandom_range(0, 9) == 0)
						base = base + 48'h1000;
					c = make_cmd(ACT_FREE, 20'($urandom()), base);
				end else if (pick < 90) begin
					c = make_cmd(ACT_FREE, 20'($urandom()), base);
				end else if (pick < 94) begin
					c = make_cmd(ACT_NONE, 20'($urandom()), base);
				end else if (pick < 97) begin
					c = make_cmd(ACT_CLEAR, 20'($urandom()), base);
				end else begin
					c = make_cmd(ACT_ALLOC, '0, base);
				end
				send_cmd(c);
				// now and then hold off until every result is back
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end
		idle_pct = 0;
	endtask

	// run sequence: reset, directed tests, random phases, drain and verdict
	initial begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			tbl_base[i]  = '0;
			tbl_pages[i] = '0;
		end
		tbl_count = 0;
		win_start = RANGE_START_RST;
		win_limit = RANGE_LIMIT_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_range_edges();
		// sender never idle, idle half the time, idle 15 percent of the time
		test_random_phase(0, 3, 50);
		test_random_phase(50, 3, 50);
		test_random_phase(15, 3, 50);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffra_pkg.sv
rtl/ffra_ram.sv
rtl/first_fit_region_allocator.sv
rtl/ffra_chk.sv
verif/tb_first_fit_region_allocator.sv
